@@ src/assert_macros.svh @@
// Assertion shorthands for the WAV header parser.
// Every check samples on the rising edge of clock and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every edge.
`define WPP_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define WPP_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define WPP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/wpp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpp_pkg
// Shared types, codes and header tables for the WAV 8-bit PCM header parser.
// ----------------------------------------------------------------------------
package wpp_pkg;

   // Header geometry
   localparam int HEADER_BYTES = 44;
   localparam int POS_W        = 6;
   localparam logic [POS_W-1:0] POS_FIRST   = 6'd0;
   localparam logic [POS_W-1:0] POS_CHAN_LO = 6'd22;
   localparam logic [POS_W-1:0] POS_CHAN_HI = 6'd23;
   localparam logic [POS_W-1:0] POS_RATE_LO = 6'd24;
   localparam logic [POS_W-1:0] POS_RATE_HI = 6'd27;
   localparam logic [POS_W-1:0] POS_LAST    = 6'(HEADER_BYTES - 1);
   localparam logic [POS_W-1:0] POS_END     = 6'(HEADER_BYTES);

   // Header bytes that must match the expected pattern exactly
   localparam logic [63:0] HDR_CHECK_MASK =
      64'h0000_000F | (64'h3FFF << 8) | (64'h3F << 34);

   // Playback divider: clock in kHz times 1000 over the sample rate
   localparam int CLK_KHZ   = 3500;
   localparam int KHZ_SCALE = 1000;
   localparam int DVD_W     = 22;
   localparam logic [DVD_W-1:0] DIVIDEND = DVD_W'(CLK_KHZ * KHZ_SCALE);
   localparam int DIV_STEPS = DVD_W / 2;
   localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_DATA,
      PH_STOP
   } phase_type;

   typedef enum logic [1:0] {
      KIND_SAMPLE,
      KIND_HEADER,
      KIND_ERROR
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_TOO_SHORT,
      ERR_NOT_PCM8,
      ERR_BAD_CHAN,
      ERR_STEREO,
      ERR_BAD_RATE
   } err_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic             emit;       // load the result register
      kind_type         kind;
      err_type          code;
      logic             last;
      logic [POS_W-1:0] pos;        // header position of this request
      logic             clear;      // restart: clear parser registers
      logic             chan_wr;    // capture channel count
      logic             rate_wr;    // write one rate byte
      logic             div_start;  // start the divider on the full rate
      logic             rem_load;   // load data byte count at header end
      logic             rem_dec;    // one sample byte spent
   } wpp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic byte_match;
      logic byte_one;
      logic byte_two;
      logic byte_zero;
      logic chan_two;
      logic rate_zero;
      logic size_short;
      logic size_is_header;
      logic rem_zero;
      logic rem_one;
      logic out_busy;
   } wpp_sts_type;

   // Expected value of each checked header byte
   function automatic logic [7:0] hdr_expected(input logic [POS_W-1:0] pos);
      logic [7:0] val;
      case (pos)
         6'd0:    val = 8'h52; // R
         6'd1:    val = 8'h49; // I
         6'd2:    val = 8'h46; // F
         6'd3:    val = 8'h46; // F
         6'd8:    val = 8'h57; // W
         6'd9:    val = 8'h41; // A
         6'd10:   val = 8'h56; // V
         6'd11:   val = 8'h45; // E
         6'd12:   val = 8'h66; // f
         6'd13:   val = 8'h6D; // m
         6'd14:   val = 8'h74; // t
         6'd15:   val = 8'h20; // space
         6'd16:   val = 8'd16; // format chunk size
         6'd20:   val = 8'd1;  // PCM
         6'd34:   val = 8'd8;  // bits per sample
         6'd36:   val = 8'h64; // d
         6'd37:   val = 8'h61; // a
         6'd38:   val = 8'h74; // t
         6'd39:   val = 8'h61; // a
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   function automatic logic hdr_checked(input logic [POS_W-1:0] pos);
      return HDR_CHECK_MASK[pos];
   endfunction

endpackage

@@ src/wpp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpp_div
// Restoring divider for the playback divider: constant dividend over the
// sample rate, two quotient bits per cycle, low 8 quotient bits kept.
// ----------------------------------------------------------------------------
module wpp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] divisor,
   output logic [7:0]  quotient,
   output logic        busy
);
   import wpp_pkg::*;

   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [7:0]        quo_ff, quo_in;
   logic [31:0]       dsr_ff, dsr_in;

   logic [DVD_W:0]    trial1, trial2, diff1, diff2;
   logic [DVD_W-1:0]  rem1;
   logic              ge1, ge2;

   // two dependent compare-subtract steps
   always_comb begin
      trial1 = {rem_ff, dvd_ff[DVD_W-1]};
      ge1    = {{(32-DVD_W-1){1'b0}}, trial1} >= dsr_ff;
      diff1  = trial1 - dsr_ff[DVD_W:0];
      rem1   = ge1 ? diff1[DVD_W-1:0] : trial1[DVD_W-1:0];
      trial2 = {rem1, dvd_ff[DVD_W-2]};
      ge2    = {{(32-DVD_W-1){1'b0}}, trial2} >= dsr_ff;
      diff2  = trial2 - dsr_ff[DVD_W:0];
   end

   // next values
   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      if (start) begin
         cnt_in = DCNT_W'(DIV_STEPS);
         rem_in = '0;
         dvd_in = DIVIDEND;
         dsr_in = divisor;
         quo_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = ge2 ? diff2[DVD_W-1:0] : trial2[DVD_W-1:0];
         dvd_in = {dvd_ff[DVD_W-3:0], 2'b00};
         quo_in = {quo_ff[5:0], ge1, ge2};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign busy     = (cnt_ff != '0);

endmodule

@@ src/wpp_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpp_dpath
// Datapath of the header parser: file size register, byte checks, rate
// assembly, divider, data byte counter and the result register.
// ----------------------------------------------------------------------------
module wpp_dpath (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_data_byte,
   input  logic                csr_write_enable,
   input  logic [31:0]         csr_write_data,
   input  wpp_pkg::wpp_cmd_type cmd,
   output wpp_pkg::wpp_sts_type sts,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_sample,
   output logic [2:0]          rsp_error_code,
   output logic [31:0]         rsp_sample_rate,
   output logic [7:0]          rsp_divider,
   output logic                rsp_last
);
   import wpp_pkg::*;
`include "assert_macros.svh"

   logic [31:0] size_ff, size_in;
   logic [31:0] rate_ff, rate_in;
   logic [1:0]  chan_ff, chan_in;
   logic [31:0] rem_ff, rem_in;

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff;
   logic [7:0]  sample_ff;
   logic [2:0]  code_ff;
   logic [31:0] srate_ff;
   logic [7:0]  div_ff;
   logic        last_ff;

   logic [31:0] rate_full;
   logic [7:0]  div_q;
   logic        div_busy;

   // rate with the top byte taken from the current request
   assign rate_full = {req_data_byte, rate_ff[23:0]};

   wpp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (rate_full),
      .quotient (div_q),
      .busy     (div_busy)
   );

   // status for the controller
   always_comb begin
      sts.byte_match     = (req_data_byte == hdr_expected(cmd.pos));
      sts.byte_one       = (req_data_byte == 8'd1);
      sts.byte_two       = (req_data_byte == 8'd2);
      sts.byte_zero      = (req_data_byte == 8'd0);
      sts.chan_two       = (chan_ff == 2'd2);
      sts.rate_zero      = (rate_full == 32'd0);
      sts.size_short     = (size_ff < 32'(HEADER_BYTES));
      sts.size_is_header = (size_ff == 32'(HEADER_BYTES));
      sts.rem_zero       = (rem_ff == 32'd0);
      sts.rem_one        = (rem_ff == 32'd1);
      sts.out_busy       = valid_ff && rsp_stall;
   end

   // parser registers
   always_comb begin
      size_in = csr_write_enable ? csr_write_data : size_ff;
      rate_in = rate_ff;
      chan_in = chan_ff;
      rem_in  = rem_ff;
      if (cmd.clear) begin
         rate_in = '0;
         chan_in = '0;
         rem_in  = '0;
      end
      if (cmd.rate_wr) begin
         rate_in[{cmd.pos[1:0], 3'b000} +: 8] = req_data_byte;
      end
      if (cmd.chan_wr) begin
         chan_in = req_data_byte[1:0];
      end
      if (cmd.rem_load) begin
         rem_in = size_ff - 32'(HEADER_BYTES);
      end else if (cmd.rem_dec) begin
         rem_in = rem_ff - 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
         rate_ff <= '0;
         chan_ff <= '0;
         rem_ff  <= '0;
      end else begin
         size_ff <= size_in;
         rate_ff <= rate_in;
         chan_ff <= chan_in;
         rem_ff  <= rem_in;
      end
   end

   // result register: held while the consumer stalls
   always_comb begin
      valid_in = valid_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         kind_ff   <= cmd.kind;
         code_ff   <= cmd.code;
         last_ff   <= cmd.last;
         sample_ff <= (cmd.kind == KIND_SAMPLE) ? req_data_byte : 8'd0;
         srate_ff  <= (cmd.kind == KIND_ERROR) ? 32'd0 : rate_ff;
         div_ff    <= (cmd.kind == KIND_ERROR) ? 8'd0 : div_q;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_sample      = sample_ff;
   assign rsp_error_code  = code_ff;
   assign rsp_sample_rate = srate_ff;
   assign rsp_divider     = div_ff;
   assign rsp_last        = last_ff;

   // divider has finished by the time the header ends
   `WPP_ASSERT_IMPL(a_div_ready, cmd.emit && (cmd.kind == KIND_HEADER), !div_busy, "divider still busy at header end")
   // a result is never lost: it shows on the port the cycle after loading
   `WPP_ASSERT_NEXT(a_rsp_loaded, cmd.emit, rsp_valid, "result not presented")

endmodule

@@ src/wpp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpp_ctrl
// Controller of the header parser: phase state machine, header position,
// error decisions and request flow control.
// ----------------------------------------------------------------------------
module wpp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_restart,
   output logic                 req_stall,
   input  wpp_pkg::wpp_sts_type sts,
   output wpp_pkg::wpp_cmd_type cmd
);
   import wpp_pkg::*;
`include "assert_macros.svh"

   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;

   phase_type         eff_phase;
   logic [POS_W-1:0]  eff_pos;
   logic              accept;
   logic              in_header;
   err_type           err;
   logic              hdr_end;

   // a request is taken whenever the result register can take a result
   assign req_stall = sts.out_busy;
   assign accept    = req_valid && !sts.out_busy;

   // restart parses the request as the first header byte
   assign eff_phase = req_restart ? PH_HEADER : phase_ff;
   assign eff_pos   = req_restart ? POS_FIRST : pos_ff;
   assign in_header = (eff_phase == PH_HEADER) && (eff_pos < POS_END);

   // header checks, first failure wins
   always_comb begin
      err = ERR_NONE;
      if (in_header) begin
         if ((eff_pos == POS_FIRST) && sts.size_short) begin
            err = ERR_TOO_SHORT;
         end else if (hdr_checked(eff_pos) && !sts.byte_match) begin
            err = ERR_NOT_PCM8;
         end else if ((eff_pos == POS_CHAN_LO) && !(sts.byte_one || sts.byte_two)) begin
            err = ERR_BAD_CHAN;
         end else if ((eff_pos == POS_CHAN_HI) && !sts.byte_zero) begin
            err = ERR_BAD_CHAN;
         end else if ((eff_pos == POS_CHAN_HI) && sts.chan_two) begin
            err = ERR_STEREO;
         end else if ((eff_pos == POS_RATE_HI) && sts.rate_zero) begin
            err = ERR_BAD_RATE;
         end
      end
   end

   assign hdr_end = in_header && (eff_pos == POS_LAST) && (err == ERR_NONE);

   // next state
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      if (accept) begin
         pos_in = in_header ? eff_pos + 1'b1 : eff_pos;
         case (eff_phase)
            PH_HEADER: begin
               if (!in_header || (err != ERR_NONE)) begin
                  phase_in = PH_STOP;
               end else if (hdr_end) begin
                  phase_in = sts.size_is_header ? PH_STOP : PH_DATA;
               end else begin
                  phase_in = PH_HEADER;
               end
            end
            PH_DATA: begin
               phase_in = (sts.rem_zero || sts.rem_one) ? PH_STOP : PH_DATA;
            end
            default: begin
               phase_in = PH_STOP;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         pos_ff   <= POS_FIRST;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

   // commands to the datapath
   always_comb begin
      cmd           = '0;
      cmd.pos       = eff_pos;
      cmd.kind      = KIND_SAMPLE;
      cmd.code      = err;
      cmd.clear     = accept && req_restart;
      cmd.chan_wr   = accept && in_header && (eff_pos == POS_CHAN_LO);
      cmd.rate_wr   = accept && in_header && (eff_pos inside {[POS_RATE_LO:POS_RATE_HI]});
      cmd.div_start = accept && in_header && (eff_pos == POS_RATE_HI);
      cmd.rem_load  = accept && hdr_end;
      cmd.rem_dec   = accept && (eff_phase == PH_DATA) && !sts.rem_zero;
      if (err != ERR_NONE) begin
         cmd.emit = accept;
         cmd.kind = KIND_ERROR;
         cmd.last = 1'b1;
      end else if (hdr_end) begin
         cmd.emit = accept;
         cmd.kind = KIND_HEADER;
      end else if ((eff_phase == PH_DATA) && !sts.rem_zero) begin
         cmd.emit = accept;
         cmd.kind = KIND_SAMPLE;
         cmd.last = sts.rem_one;
      end
   end

   // results only ever come from accepted requests
   `WPP_ASSERT_IMPL(a_emit_accepted, cmd.emit, accept, "result without accepted request")
   // an accepted header leaves the header phase
   `WPP_ASSERT_NEXT(a_hdr_leaves, accept && hdr_end, phase_ff != PH_HEADER, "parser stuck in header")

endmodule

@@ src/wav_pcm8_header_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_pcm8_header_parser
// Checks the 44-byte header of an 8-bit mono PCM WAV file and passes the
// sample bytes through with the sample rate and playback divider.
// ----------------------------------------------------------------------------
// Each request is one file byte and a byte may follow in every cycle;
// req_stall is raised only while a result waits in the output register
// and rsp_stall is high. A header result comes out on the last header
// byte, with the sample rate and (3500000 / rate) mod 256. That divider
// is worked out by a two-bit-per-cycle restoring divider that starts on
// the last rate byte, hidden behind the sixteen header bytes that follow.
// The first header fault gives one error result marked last; later bytes
// are dropped until a request with req_restart set, which is itself parsed
// as header byte 0. The user must write file_size via csr_write_enable and
// csr_write_data only while the block is idle; the block does not check it.
// ----------------------------------------------------------------------------
module wav_pcm8_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_sample,
   output logic [2:0]  rsp_error_code,
   output logic [31:0] rsp_sample_rate,
   output logic [7:0]  rsp_divider,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);
   import wpp_pkg::*;

   wpp_cmd_type cmd;
   wpp_sts_type sts;

   wpp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   wpp_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_data_byte    (req_data_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_sample       (rsp_sample),
      .rsp_error_code   (rsp_error_code),
      .rsp_sample_rate  (rsp_sample_rate),
      .rsp_divider      (rsp_divider),
      .rsp_last         (rsp_last)
   );

endmodule
